### src/tile_lightness_to_char_mapper_top_macros.svh
// assertion macros for the tile mapper modules; only tlc_back includes them
// depends on nothing; included by files that carry assertions
`ifndef TILE_LIGHTNESS_TO_CHAR_MAPPER_TOP_MACROS_SVH
`define TILE_LIGHTNESS_TO_CHAR_MAPPER_TOP_MACROS_SVH
// implication checked on every edge out of reset
`define TLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define TLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/tlc_pkg.sv
// shared types and constants for the tile lightness to character mapper
// depends on nothing
package tlc_pkg;
    localparam int MaxImageWidth = 1024;
    localparam int SumW = 21;
    localparam int ColW = 10;
    localparam int RowW = 12;
    localparam int TileW = 6;
    localparam int NumW = 26;            // palette count times sum
    localparam int DenW = 21;            // 510 * 64 * 64 fits
    localparam int IdxW = 5;
    localparam logic [7:0] NewlineCode = 8'd10;
    localparam logic [2:0] RegImageWidth = 3'd0;
    localparam logic [2:0] RegImageHeight = 3'd1;
    localparam logic [2:0] RegTileWidth = 3'd2;
    localparam logic [2:0] RegTileHeight = 3'd3;
    localparam logic [2:0] RegPaletteCount = 3'd4;
    localparam logic [2:0] RegPaletteLow = 3'd5;
    localparam logic [2:0] RegPaletteHigh = 3'd6;

    // finished tile passed from front to back
    typedef struct packed {
        logic [SumW-1:0] sum;
        logic            newline;
        logic            frame_end;
    } tile_job_t;
endpackage

### src/tile_lightness_to_char_mapper_top.sv
// Tile lightness to character mapper: pixels in raster order, one may be taken per cycle
// while the job queue has room; each finished tile passes through the back end in order
// (queue pop, multiply, five-step serial divide, character, optional newline), so tiles
// finishing faster than the back end drains them stall the input. Configuration must change
// only while idle. Reset leaves the accumulator memory undefined; it is written before read.
module tile_lightness_to_char_mapper_top
    import tlc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue from bit 0
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_code
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser,   // frame_done
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic [10:0] iw_reg; logic [12:0] ih_reg; logic [6:0] tw_reg, th_reg;
    logic [4:0]  pc_reg; logic [63:0] pl_reg, ph_reg;
    logic [10:0] iw; logic [12:0] ih; logic [6:0] tw, th; logic [4:0] pc;
    logic        job_valid, job_space;
    tile_job_t   job;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iw_reg <= 11'd1; ih_reg <= 13'd1; tw_reg <= 7'd1; th_reg <= 7'd1;
            pc_reg <= 5'd11; pl_reg <= '0; ph_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegImageWidth:   iw_reg <= cfg_data[10:0];
                RegImageHeight:  ih_reg <= cfg_data[12:0];
                RegTileWidth:    tw_reg <= cfg_data[6:0];
                RegTileHeight:   th_reg <= cfg_data[6:0];
                RegPaletteCount: pc_reg <= cfg_data[4:0];
                RegPaletteLow:   pl_reg <= cfg_data;
                RegPaletteHigh:  ph_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped working values
    always_comb begin
        iw = (iw_reg == '0) ? 11'd1 : (iw_reg > 11'd1024 ? 11'd1024 : iw_reg);
        ih = (ih_reg == '0) ? 13'd1 : (ih_reg > 13'd4096 ? 13'd4096 : ih_reg);
        tw = (tw_reg == '0) ? 7'd1 : (tw_reg > 7'd64 ? 7'd64 : tw_reg);
        th = (th_reg == '0) ? 7'd1 : (th_reg > 7'd64 ? 7'd64 : th_reg);
        pc = (pc_reg == '0) ? 5'd1 : (pc_reg > 5'd16 ? 5'd16 : pc_reg);
    end

    tlc_front u_front (
        .aclk(aclk), .aresetn(aresetn), .red(s_tdata[7:0]), .green(s_tdata[15:8]),
        .blue(s_tdata[23:16]), .frame_start(s_tuser), .in_valid(s_tvalid),
        .in_ready(s_tready), .iw(iw), .ih(ih), .tw(tw), .th(th),
        .job_valid(job_valid), .job(job), .job_space(job_space)
    );

    tlc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(job_valid), .job(job),
        .job_space(job_space), .tw(tw), .th(th), .pc(pc), .pal_low(pl_reg),
        .pal_high(ph_reg), .out_valid(m_tvalid), .out_char(m_tdata),
        .out_last(m_tlast), .out_done(m_tuser), .out_ready(m_tready)
    );
endmodule

### src/tlc_front.sv
// front part: position counters, lightness, per-tile-column accumulator memory
// depends on tlc_pkg
module tlc_front
    import tlc_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    input  logic            frame_start,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [10:0]     iw,
    input  logic [12:0]     ih,
    input  logic [6:0]      tw,
    input  logic [6:0]      th,
    output logic            job_valid,
    output tile_job_t       job,
    input  logic            job_space
);
    logic [SumW-1:0] sums_mem [MaxImageWidth];
    logic [ColW-1:0]  pcol_reg, pcol_next;
    logic [RowW-1:0]  prow_reg, prow_next;
    logic [TileW-1:0] cit_reg, cit_next, rit_reg, rit_next;
    logic [ColW-1:0]  tcol_reg, tcol_next;
    // stage 1 holds an accepted pixel while the memory is read
    logic             s1_valid_reg;
    logic [8:0]       s1_light_reg;
    logic             s1_first_reg, s1_emit_reg, s1_lc_reg, s1_lr_reg;
    logic [ColW-1:0]  s1_slot_reg;
    logic [SumW-1:0]  rd_reg;
    // bypass of a write to the same slot in the previous cycle
    logic             wr_valid_reg;
    logic [ColW-1:0]  wr_slot_reg;
    logic [SumW-1:0]  wr_data_reg;
    logic [ColW-1:0]  c_pcol, c_tcol;
    logic [RowW-1:0]  c_prow;
    logic [TileW-1:0] c_cit, c_rit;
    logic [7:0]       hi, lo;
    logic             last_col, last_row, tx_end, ty_end, take;
    logic [SumW-1:0]  prev_sum, new_sum;

    assign in_ready = job_space;
    assign take = in_valid && in_ready;

    // counters as seen by this pixel
    always_comb begin
        c_pcol = frame_start ? '0 : pcol_reg;
        c_prow = frame_start ? '0 : prow_reg;
        c_cit  = frame_start ? '0 : cit_reg;
        c_rit  = frame_start ? '0 : rit_reg;
        c_tcol = frame_start ? '0 : tcol_reg;
        hi = red; lo = red;
        if (green > hi) hi = green;
        if (blue > hi) hi = blue;
        if (green < lo) lo = green;
        if (blue < lo) lo = blue;
        last_col = {1'b0, c_pcol} >= iw - 11'd1;
        last_row = {1'b0, c_prow} >= ih - 13'd1;
        tx_end = last_col || ({1'b0, c_cit} >= tw - 7'd1);
        ty_end = last_row || ({1'b0, c_rit} >= th - 7'd1);
    end

    // next position
    always_comb begin
        pcol_next = c_pcol; prow_next = c_prow; cit_next = c_cit;
        rit_next = c_rit; tcol_next = c_tcol;
        if (last_col) begin
            pcol_next = '0; cit_next = '0; tcol_next = '0;
            if (last_row) begin
                prow_next = '0; rit_next = '0;
            end else begin
                prow_next = c_prow + 1'b1;
                rit_next = ({1'b0, c_rit} >= th - 7'd1) ? '0 : c_rit + 1'b1;
            end
        end else begin
            pcol_next = c_pcol + 1'b1;
            if ({1'b0, c_cit} >= tw - 7'd1) begin
                cit_next = '0; tcol_next = c_tcol + 1'b1;
            end else begin
                cit_next = c_cit + 1'b1;
            end
        end
    end

    // position and stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcol_reg <= '0; prow_reg <= '0; cit_reg <= '0; rit_reg <= '0;
            tcol_reg <= '0; s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= take;
            if (take) begin
                pcol_reg <= pcol_next; prow_reg <= prow_next; cit_reg <= cit_next;
                rit_reg <= rit_next; tcol_reg <= tcol_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_light_reg <= {1'b0, hi} + {1'b0, lo};
            s1_first_reg <= (c_cit == '0) && (c_rit == '0);
            s1_emit_reg  <= tx_end && ty_end;
            s1_lc_reg    <= last_col;
            s1_lr_reg    <= last_row;
            s1_slot_reg  <= c_tcol;
        end
    end

    // accumulator memory: one read, one write per cycle
    always_ff @(posedge aclk) begin
        rd_reg <= sums_mem[c_tcol];
        if (s1_valid_reg) sums_mem[s1_slot_reg] <= new_sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) wr_valid_reg <= 1'b0;
        else wr_valid_reg <= s1_valid_reg;
        wr_slot_reg <= s1_slot_reg;
        wr_data_reg <= new_sum;
    end

    always_comb begin
        prev_sum = (wr_valid_reg && wr_slot_reg == s1_slot_reg) ? wr_data_reg : rd_reg;
        new_sum = s1_first_reg ? SumW'(s1_light_reg) : prev_sum + SumW'(s1_light_reg);
    end

    assign job_valid = s1_valid_reg && s1_emit_reg;
    assign job.sum = new_sum;
    assign job.newline = s1_lc_reg;
    assign job.frame_end = s1_lc_reg && s1_lr_reg;
endmodule

### src/tlc_back.sv
// back part: tile job queue, serial divider for palette index, output register
// depends on tlc_pkg and the macros header
`include "tile_lightness_to_char_mapper_top_macros.svh"
module tlc_back
    import tlc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    input  tile_job_t   job,
    output logic        job_space,
    input  logic [6:0]  tw,
    input  logic [6:0]  th,
    input  logic [4:0]  pc,
    input  logic [63:0] pal_low,
    input  logic [63:0] pal_high,
    output logic        out_valid,
    output logic [7:0]  out_char,
    output logic        out_last,
    output logic        out_done,
    input  logic        out_ready
);
    localparam int QDepth = 4;
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StMul = 3'd1;
    localparam logic [2:0] StDiv = 3'd2;
    localparam logic [2:0] StChar = 3'd3;
    localparam logic [2:0] StNl = 3'd4;

    tile_job_t       q_mem [QDepth];
    logic [1:0]      wp_reg, rp_reg;
    logic [2:0]      cnt_reg;
    logic [2:0]      st_reg;
    tile_job_t       cur_reg;
    logic [NumW-1:0] rem_reg;
    logic [DenW-1:0] den_reg;
    logic [IdxW-1:0] quo_reg;
    logic [4:0]      step_reg;
    logic            ov_reg, ol_reg, od_reg;
    logic [7:0]      oc_reg;
    logic            pop, push, o_free;
    logic [NumW:0]   trial;
    logic [IdxW-1:0] idx;
    logic [3:0]      slot;
    logic [7:0]      pch;

    // a pixel is taken only while at least two job slots remain, which covers pipe latency
    assign job_space = cnt_reg <= 3'(QDepth - 2);
    assign push = job_valid;
    assign pop = (st_reg == StIdle) && (cnt_reg != '0);
    assign o_free = !ov_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (push) q_mem[wp_reg] <= job;
    end

    // restoring division: quotient bits from bit 4 down, one a cycle
    assign trial = {1'b0, rem_reg} - ({(NumW+1){1'b0}} | ({6'd0, den_reg} << step_reg));
    always_comb begin
        idx = (quo_reg > IdxW'(pc - 5'd1)) ? IdxW'(pc - 5'd1) : quo_reg;
        slot = idx[3:0];
        pch = slot[3] ? pal_high[8*slot[2:0] +: 8] : pal_low[8*slot[2:0] +: 8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0; st_reg <= StIdle; ov_reg <= 1'b0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
            // output item loaded from the character and newline states, held until taken
            ov_reg <= ((st_reg == StChar || st_reg == StNl) && o_free)
                      || (ov_reg && !out_ready);
            unique case (st_reg)
                StIdle: if (pop) st_reg <= StMul;
                StMul:  st_reg <= StDiv;
                StDiv:  if (step_reg == '0) st_reg <= StChar;
                StChar: if (o_free) begin
                    st_reg <= cur_reg.newline ? StNl : StIdle;
                end
                StNl: if (o_free) begin
                    st_reg <= StIdle;
                end
                default: st_reg <= StIdle;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            StIdle: cur_reg <= q_mem[rp_reg];
            StMul: begin
                rem_reg <= NumW'(pc) * NumW'(cur_reg.sum);
                den_reg <= DenW'(10'd510 * 14'(tw * th));
                quo_reg <= '0; step_reg <= 5'd4;
            end
            StDiv: begin
                if (!trial[NumW]) begin
                    rem_reg <= trial[NumW-1:0];
                    quo_reg[step_reg[2:0]] <= 1'b1;
                end
                if (step_reg != '0) step_reg <= step_reg - 1'b1;
            end
            StChar: if (o_free) begin
                oc_reg <= pch; ol_reg <= !cur_reg.newline; od_reg <= 1'b0;
            end
            StNl: if (o_free) begin
                oc_reg <= NewlineCode; ol_reg <= 1'b1; od_reg <= cur_reg.frame_end;
            end
            default: ;
        endcase
    end

    assign out_valid = ov_reg;
    assign out_char = oc_reg;
    assign out_last = ol_reg;
    assign out_done = od_reg;

    `TLC_ASSERT_IMP(a_no_overflow, push, cnt_reg < 3'(QDepth), "job queue overflow")
    `TLC_ASSERT_IMP(a_done_last, out_valid && out_done, out_last, "frame end not last")
    `TLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char), "output dropped")
endmodule

### tb/sv/tile_lightness_to_char_mapper_top_test.sv
// self-checking bench for the tile lightness to character mapper
// drives pixel items, predicts characters and newlines, checks the result stream
// depends on tlc_pkg and tile_lightness_to_char_mapper_top
`timescale 1ns / 100ps

module tile_lightness_to_char_mapper_top_test;
    import tlc_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_of_run;
        logic       frame_done;
    } glyph_t;

    localparam int StallLimit = 20000;
    localparam int DrainCycles = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    tile_lightness_to_char_mapper_top dut (.*);

    always #4 aclk = ~aclk;

    // predictor copy of configuration and position state
    logic [10:0] img_w;
    logic [12:0] img_h;
    logic [6:0]  tile_w, tile_h;
    logic [4:0]  pal_count;
    logic [63:0] pal_lo, pal_hi;
    logic [20:0] col_sums [MaxImageWidth];
    int unsigned px_col, px_row, col_in_tile, row_in_tile, tile_col;

    pixel_t pending_pixels[$];
    glyph_t expected_glyphs[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  gaps_on = 1'b1;
    bit  in_taken = 1'b0;
    int  send_gap = 0, recv_gap = 0;

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [7:0] palette_byte(int unsigned idx);
        idx = idx & 15;
        return idx < 8 ? pal_lo[8*idx +: 8] : pal_hi[8*(idx-8) +: 8];
    endfunction

    // work out the glyphs one pixel produces and advance the position state
    task automatic predict_glyphs(pixel_t p);
        int unsigned iw, ih, tw, th, pc, hi_c, lo_c, light, sum;
        longint unsigned idx;
        bit last_col, last_row;
        glyph_t g;
        iw = clip(img_w, 1, MaxImageWidth);
        ih = clip(img_h, 1, 4096);
        tw = clip(tile_w, 1, 64);
        th = clip(tile_h, 1, 64);
        pc = clip(pal_count, 1, 16);
        if (p.frame_start) begin
            px_col = 0; px_row = 0; col_in_tile = 0; row_in_tile = 0; tile_col = 0;
        end
        hi_c = p.red; lo_c = p.red;
        if (p.green > hi_c) hi_c = p.green;
        if (p.blue > hi_c) hi_c = p.blue;
        if (p.green < lo_c) lo_c = p.green;
        if (p.blue < lo_c) lo_c = p.blue;
        light = hi_c + lo_c;
        if (col_in_tile == 0 && row_in_tile == 0) sum = light;
        else sum = (col_sums[tile_col % MaxImageWidth] + light) & 21'h1FFFFF;
        col_sums[tile_col % MaxImageWidth] = 21'(sum);
        last_col = px_col >= iw - 1;
        last_row = px_row >= ih - 1;
        if ((last_col || col_in_tile >= tw - 1) && (last_row || row_in_tile >= th - 1)) begin
            idx = (longint'(pc) * sum) / (longint'(510) * tw * th);
            if (idx > pc - 1) idx = pc - 1;
            g.char_code = palette_byte(32'(idx));
            g.last_of_run = !last_col;
            g.frame_done = 1'b0;
            expected_glyphs.push_back(g);
            if (last_col) begin
                g.char_code = NewlineCode;
                g.last_of_run = 1'b1;
                g.frame_done = last_row;
                expected_glyphs.push_back(g);
            end
        end
        if (last_col) begin
            px_col = 0; col_in_tile = 0; tile_col = 0;
            if (last_row) begin
                px_row = 0; row_in_tile = 0;
            end else begin
                px_row = (px_row + 1) & 12'hFFF;
                row_in_tile = (row_in_tile >= th - 1) ? 0 : ((row_in_tile + 1) & 6'h3F);
            end
        end else begin
            px_col = (px_col + 1) & 10'h3FF;
            if (col_in_tile >= tw - 1) begin
                col_in_tile = 0;
                tile_col = (tile_col + 1) & 10'h3FF;
            end else begin
                col_in_tile = (col_in_tile + 1) & 6'h3F;
            end
        end
    endtask

    // pixel driver, acting on the handshake seen at the last rising edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                predict_glyphs(pixel_t'({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tuser}));
                void'(pending_pixels.pop_front());
                if (gaps_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 5);
            end
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= {pending_pixels[0].blue, pending_pixels[0].green,
                            pending_pixels[0].red};
                s_tuser <= pending_pixels[0].frame_start;
            end else begin
                s_tvalid <= 1'b0;
            end
            // result back-pressure
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 5);
            end
        end
    end

    // result monitor and watchdog
    always @(posedge aclk) begin
        glyph_t want;
        if (aresetn) begin
            in_taken <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > StallLimit) begin
                $display("tile_lightness_to_char_mapper_top_test: errors");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (expected_glyphs.size() == 0) begin
                    $error("unexpected item char_code %0d", m_tdata);
                    error_count++;
                end else begin
                    want = expected_glyphs.pop_front();
                    if (m_tdata !== want.char_code) begin
                        $error("char_code expected %0d actual %0d", want.char_code, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last_of_run) begin
                        $error("last_of_run expected %0d actual %0d", want.last_of_run, m_tlast);
                        error_count++;
                    end
                    if (m_tuser !== want.frame_done) begin
                        $error("frame_done expected %0d actual %0d", want.frame_done, m_tuser);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            RegImageWidth:   img_w = val[10:0];
            RegImageHeight:  img_h = val[12:0];
            RegTileWidth:    tile_w = val[6:0];
            RegTileHeight:   tile_h = val[6:0];
            RegPaletteCount: pal_count = val[4:0];
            RegPaletteLow:   pal_lo = val;
            RegPaletteHigh:  pal_hi = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int w, int h, int tw, int th, int pc);
        write_reg(RegImageWidth, w);
        write_reg(RegImageHeight, h);
        write_reg(RegTileWidth, tw);
        write_reg(RegTileHeight, th);
        write_reg(RegPaletteCount, pc);
        write_reg(RegPaletteLow, {$urandom, $urandom});
        write_reg(RegPaletteHigh, {$urandom, $urandom});
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((pending_pixels.size() > 0 || expected_glyphs.size() > 0 || s_tvalid)
               && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // whole frames, first pixel flagged or not; mode 1 all white, mode 2 all black, else random
    task automatic queue_frame(int w, int h, bit flagged, int mode);
        pixel_t p;
        for (int i = 0; i < w * h; i++) begin
            p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
            if (mode == 1) begin
                p.red = 8'hFF; p.green = 8'hFF; p.blue = 8'hFF;
            end else if (mode == 2) begin
                p.red = 0; p.green = 0; p.blue = 0;
            end
            p.frame_start = (i == 0) && flagged;
            pending_pixels.push_back(p);
        end
    endtask

    initial begin
        int w, h;
        img_w = 1; img_h = 1; tile_w = 1; tile_h = 1; pal_count = 11; pal_lo = 0; pal_hi = 0;
        px_col = 0; px_row = 0; col_in_tile = 0; row_in_tile = 0; tile_col = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // directed: reset settings, extremes of lightness and palette count
        queue_frame(1, 1, 1, 1);
        queue_frame(1, 1, 0, 2);
        wait_idle();
        set_geometry(4, 3, 2, 2, 16);
        queue_frame(4, 3, 1, 1);
        wait_idle();
        set_geometry(5, 2, 64, 64, 1);
        queue_frame(5, 2, 0, 0);
        wait_idle();
        set_geometry(3, 3, 0, 0, 0);
        queue_frame(3, 3, 1, 2);
        wait_idle();
        // wide tiles with a narrow edge tile
        set_geometry(130, 1, 64, 1, 31);
        queue_frame(130, 1, 1, 0);
        wait_idle();
        set_geometry(2, 4096, 1, 64, 16);
        queue_frame(2, 16, 1, 0);
        // flagged restart mid-frame on full-height image
        queue_frame(2, 3, 1, 0);
        wait_idle();
        // random frames with random geometry, first frame always flagged
        for (int k = 0; k < 6; k++) begin
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 6);
            set_geometry(w, h, $urandom_range(1, 5), $urandom_range(1, 4),
                         $urandom_range(1, 16));
            if (k >= 4) gaps_on = 1'b0;
            for (int f = 0; f < 3; f++)
                queue_frame(w, h, (f == 0) || ($urandom_range(0, 1) == 1), 0);
            wait_idle();
        end
        if (expected_glyphs.size() != 0) begin
            $error("items still expected: %0d", expected_glyphs.size());
            error_count++;
        end
        if (error_count == 0) $display("tile_lightness_to_char_mapper_top_test: clean");
        else $display("tile_lightness_to_char_mapper_top_test: errors");
        $finish;
    end
endmodule
